FILE: design/mssl_pkg.sv
// shared types, constants and helper functions of the multi-servo slew limiter
// used by every module under design/; depends on nothing else
package mssl_pkg;

	// fixed field widths
	localparam int ANGLE_W = 8;
	localparam int COUNT_W = 12;
	localparam int NUM_W   = 5;
	localparam int CHAN_W  = 4;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	// default sizing
	localparam int SERVO_TOTAL_DEF = 18;
	localparam int LEFT_SERVOS_DEF = 9;

	// angle limits and group presets
	localparam logic [ANGLE_W-1:0] MAX_ANGLE   = 8'd180;
	localparam logic [ANGLE_W-1:0] PRESET_MID  = 8'd90;
	localparam logic [ANGLE_W-1:0] PRESET_L1   = 8'd165;
	localparam logic [ANGLE_W-1:0] PRESET_L2   = 8'd180;
	localparam logic [ANGLE_W-1:0] PRESET_R1   = 8'd15;
	localparam logic [ANGLE_W-1:0] PRESET_R2   = 8'd0;
	localparam int                 GROUP_SIZE  = 3;

	// register reset values
	localparam logic [7:0]         STEP_RST = 8'd5;
	localparam logic [COUNT_W-1:0] ZERO_RST = 12'd500;
	localparam logic [COUNT_W-1:0] FULL_RST = 12'd100;

	// register indexes
	localparam logic [1:0] REG_STEP = 2'd0;
	localparam logic [1:0] REG_ZERO = 2'd1;
	localparam logic [1:0] REG_FULL = 2'd2;

	// operation codes
	localparam logic OP_SET_TARGET = 1'b0;
	localparam logic OP_TICK       = 1'b1;

	// divide by 180: drop two bits, then divide by 45 through a reciprocal
	localparam int MAP_DIV_SHIFT   = 2;
	localparam int MAP_DIV_RESID   = 45;
	localparam int MAP_RECIP_SHIFT = 24;
	localparam int MAP_RECIP       = ((2 ** MAP_RECIP_SHIFT) - 1) / MAP_DIV_RESID;
	localparam int MAP_X_W         = 18;
	localparam int MAP_RECIP_W     = 19;

	// configuration register set
	typedef struct packed {
		logic [7:0]         step;
		logic [COUNT_W-1:0] zero;
		logic [COUNT_W-1:0] full;
	} cfg_t;

	// controller to datapath commands
	typedef struct packed {
		logic set_target;
		logic tick_start;
		logic step;
		logic mul;
		logic div;
		logic load;
		logic load_empty;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic none_moving;
		logic mover;
		logic last_mover;
		logic load_ok;
	} status_t;

	// reset angle of a servo from its group of three on its side
	function automatic logic [ANGLE_W-1:0] preset_angle(input int idx, input int left);
		logic          right;
		int            loc;
		logic [ANGLE_W-1:0] val;
		right = (idx >= left);
		loc   = right ? idx - left : idx;
		if (loc < GROUP_SIZE) begin
			val = PRESET_MID;
		end else if (loc < 2 * GROUP_SIZE) begin
			val = right ? PRESET_R1 : PRESET_L1;
		end else begin
			val = right ? PRESET_R2 : PRESET_L2;
		end
		return val;
	endfunction

endpackage

FILE: design/mssl_regs.sv
// configuration registers and apb-style access port of the slew limiter
// depends on mssl_pkg
module mssl_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mssl_pkg::ADDR_W-1:0]   paddr,
	input  logic [mssl_pkg::DATA_W-1:0]   pwdata,
	output logic [mssl_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output mssl_pkg::cfg_t                cfg
);

	logic [7:0]                    step_q;
	logic [mssl_pkg::COUNT_W-1:0]  zero_q;
	logic [mssl_pkg::COUNT_W-1:0]  full_q;
	logic                          wr_en;
	logic [1:0]                    reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= mssl_pkg::STEP_RST;
			zero_q <= mssl_pkg::ZERO_RST;
			full_q <= mssl_pkg::FULL_RST;
		end else if (wr_en) begin
			case (reg_sel)
				mssl_pkg::REG_STEP: step_q <= pwdata[7:0];
				mssl_pkg::REG_ZERO: zero_q <= pwdata[mssl_pkg::COUNT_W-1:0];
				mssl_pkg::REG_FULL: full_q <= pwdata[mssl_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_sel)
			mssl_pkg::REG_STEP: prdata = {24'd0, step_q};
			mssl_pkg::REG_ZERO: prdata = {20'd0, zero_q};
			mssl_pkg::REG_FULL: prdata = {20'd0, full_q};
			default:            prdata = '0;
		endcase
	end

	assign cfg.step = step_q;
	assign cfg.zero = zero_q;
	assign cfg.full = full_q;

endmodule

FILE: design/mssl_ctrl.sv
// sequencing state machine of the slew limiter: request intake, servo scan
// and result hand-off; depends on mssl_pkg
module mssl_ctrl #(
	parameter int SERVO_TOTAL = mssl_pkg::SERVO_TOTAL_DEF,
	parameter int IDX_W       = $clog2(SERVO_TOTAL)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  mssl_pkg::status_t  status,
	output mssl_pkg::cmd_t     cmd,
	output logic [IDX_W-1:0]   idx
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_SCAN  = 6'b000010,
		ST_MUL   = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_FIX   = 6'b010000,
		ST_EMPTY = 6'b100000
	} state_t;

	state_t           state_q, state_d;
	logic [IDX_W-1:0] idx_q, idx_d;

	assign in_stall = (state_q != ST_IDLE);
	assign idx      = idx_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (operation == mssl_pkg::OP_TICK) begin
						cmd.tick_start = 1'b1;
						idx_d          = '0;
						state_d        = status.none_moving ? ST_EMPTY : ST_SCAN;
					end else begin
						cmd.set_target = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (status.mover) begin
					cmd.step = 1'b1;
					state_d  = ST_MUL;
				end else if (idx_q == IDX_W'(SERVO_TOTAL - 1)) begin
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				state_d = ST_FIX;
			end
			ST_FIX: begin
				if (status.load_ok) begin
					cmd.load = 1'b1;
					if (status.last_mover || idx_q == IDX_W'(SERVO_TOTAL - 1)) begin
						state_d = ST_IDLE;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_EMPTY: begin
				if (status.load_ok) begin
					cmd.load_empty = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

endmodule

FILE: design/mssl_datapath.sv
// servo angle store, slew step, angle-to-count map and output register
// depends on mssl_pkg; driven by mssl_ctrl commands
module mssl_datapath #(
	parameter int SERVO_TOTAL = mssl_pkg::SERVO_TOTAL_DEF,
	parameter int LEFT_SERVOS = mssl_pkg::LEFT_SERVOS_DEF,
	parameter int IDX_W       = $clog2(SERVO_TOTAL)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mssl_pkg::cfg_t                cfg,
	input  mssl_pkg::cmd_t                cmd,
	input  logic [IDX_W-1:0]              idx,
	output mssl_pkg::status_t             status,
	input  logic [mssl_pkg::NUM_W-1:0]    servo_number,
	input  logic [mssl_pkg::ANGLE_W-1:0]  target_angle,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          write_valid,
	output logic                          controller_side,
	output logic [mssl_pkg::CHAN_W-1:0]   channel,
	output logic [mssl_pkg::COUNT_W-1:0]  pwm_count,
	output logic                          all_settled,
	output logic                          last
);

	localparam int AW = mssl_pkg::ANGLE_W;
	localparam int CW = mssl_pkg::COUNT_W;
	localparam int XW = mssl_pkg::MAP_X_W;
	localparam int RW = mssl_pkg::MAP_RECIP_W;

	// per-servo state
	logic [AW-1:0]          cur_q [SERVO_TOTAL];
	logic [AW-1:0]          tgt_q [SERVO_TOTAL];
	logic [SERVO_TOTAL-1:0] pend_q;
	logic [SERVO_TOTAL-1:0] mov_q;
	logic                   settled_q;

	// map pipeline
	logic [AW-1:0]          next_s1;
	logic signed [21:0]     prod_s2;
	logic [XW-1:0]          x_s3;
	logic [CW-1:0]          q0_s3;
	logic                   neg_s3;

	// output register
	logic                   out_v_q;
	logic                   wv_q;
	logic                   side_q;
	logic [3:0]             chan_q;
	logic [CW-1:0]          cnt_q;
	logic                   settled_out_q;
	logic                   last_q;

	logic [SERVO_TOTAL-1:0] move_vec;
	logic                   num_ok;
	logic [IDX_W-1:0]       set_idx;
	logic [AW-1:0]          sat_tgt;
	logic [AW-1:0]          cur_a, des_a, step_a, gap, next_angle;
	logic [SERVO_TOTAL-1:0] later;
	logic                   right;
	logic [5:0]             chan_wide;
	logic signed [12:0]     span;
	logic [21:0]            mag;
	logic [XW-1:0]          x_val;
	logic [XW+RW-1:0]       recip_prod;
	logic [XW-1:0]          resid;
	logic [CW-1:0]          quot;
	logic [CW-1:0]          count_val;

	// servos that move on the coming tick; these are also the ones left pending
	always_comb begin
		for (int i = 0; i < SERVO_TOTAL; i++) begin
			move_vec[i] = pend_q[i] & (cur_q[i] != tgt_q[i]);
		end
	end

	// set-target decode
	assign num_ok  = (servo_number != '0) &&
	                 ({1'b0, servo_number} <= 6'(SERVO_TOTAL));
	assign set_idx = IDX_W'(servo_number - 1'b1);
	assign sat_tgt = (target_angle > mssl_pkg::MAX_ANGLE) ? mssl_pkg::MAX_ANGLE : target_angle;

	// slew step of the scanned servo
	assign cur_a  = cur_q[idx];
	assign des_a  = tgt_q[idx];
	assign step_a = (cfg.step == '0) ? 8'd1 : cfg.step;
	assign gap    = (des_a > cur_a) ? des_a - cur_a : cur_a - des_a;
	always_comb begin
		if (gap <= step_a) begin
			next_angle = des_a;
		end else if (des_a > cur_a) begin
			next_angle = cur_a + step_a;
		end else begin
			next_angle = cur_a - step_a;
		end
	end

	// side and channel of the scanned servo
	assign right     = ({1'b0, idx} >= 6'(LEFT_SERVOS));
	assign chan_wide = right ? 6'({1'b0, idx}) - 6'(LEFT_SERVOS) : 6'({1'b0, idx});

	// no later mover in this tick
	assign later = mov_q >> idx;

	// magnitude of the product divided by 180, truncated toward zero
	assign span       = $signed({1'b0, cfg.full}) - $signed({1'b0, cfg.zero});
	assign mag        = prod_s2[21] ? 22'(-prod_s2) : 22'(prod_s2);
	assign x_val      = mag[XW+mssl_pkg::MAP_DIV_SHIFT-1:mssl_pkg::MAP_DIV_SHIFT];
	assign recip_prod = (XW+RW)'(x_val) * (XW+RW)'(mssl_pkg::MAP_RECIP);
	assign resid      = x_s3 - XW'(q0_s3) * XW'(mssl_pkg::MAP_DIV_RESID);
	assign quot       = (resid >= XW'(mssl_pkg::MAP_DIV_RESID)) ? q0_s3 + 1'b1 : q0_s3;
	assign count_val  = neg_s3 ? cfg.zero - quot : cfg.zero + quot;

	// status to the controller
	assign status.none_moving = (move_vec == '0);
	assign status.mover       = mov_q[idx];
	assign status.last_mover  = ((later >> 1) == '0);
	assign status.load_ok     = !out_v_q || !out_stall;

	// servo state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SERVO_TOTAL; i++) begin
				cur_q[i] <= mssl_pkg::preset_angle(i, LEFT_SERVOS);
				tgt_q[i] <= mssl_pkg::preset_angle(i, LEFT_SERVOS);
			end
			pend_q    <= '0;
			mov_q     <= '0;
			settled_q <= 1'b1;
		end else begin
			if (cmd.set_target && num_ok) begin
				tgt_q[set_idx]  <= sat_tgt;
				pend_q[set_idx] <= 1'b1;
			end
			if (cmd.tick_start) begin
				pend_q    <= move_vec;
				mov_q     <= move_vec;
				settled_q <= (move_vec == '0);
			end
			if (cmd.step) begin
				cur_q[idx] <= next_angle;
			end
		end
	end

	// angle-to-count pipeline
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			next_s1 <= next_angle;
		end
		if (cmd.mul) begin
			prod_s2 <= 22'($signed({1'b0, next_s1}) * span);
		end
		if (cmd.div) begin
			x_s3   <= x_val;
			q0_s3  <= CW'(recip_prod >> mssl_pkg::MAP_RECIP_SHIFT);
			neg_s3 <= prod_s2[21];
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.load || cmd.load_empty) begin
			out_v_q <= 1'b1;
		end else if (!out_stall) begin
			out_v_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wv_q          <= 1'b1;
			side_q        <= right;
			chan_q        <= chan_wide[3:0];
			cnt_q         <= count_val;
			settled_out_q <= settled_q;
			last_q        <= status.last_mover;
		end else if (cmd.load_empty) begin
			wv_q          <= 1'b0;
			side_q        <= 1'b0;
			chan_q        <= '0;
			cnt_q         <= '0;
			settled_out_q <= settled_q;
			last_q        <= 1'b1;
		end
	end

	assign out_valid       = out_v_q;
	assign write_valid     = wv_q;
	assign controller_side = side_q;
	assign channel         = chan_q;
	assign pwm_count       = cnt_q;
	assign all_settled     = settled_out_q;
	assign last            = last_q;

endmodule

FILE: design/multi_servo_slew_limiter.sv
// multi-servo slew limiter: a set-target request is stored while idle; a tick scans servo
// indexes from zero up to the last moving servo, and each move runs through step, multiply,
// reciprocal divide and output load, the load held by any output stall; an idle tick loads
// one empty result; one request at a time, the next taken while the final result waits
// arst_n clears control state and restores the preset angles and register defaults at once
// depends on mssl_pkg, mssl_regs, mssl_ctrl, mssl_datapath
module multi_servo_slew_limiter #(
	parameter int SERVO_TOTAL = mssl_pkg::SERVO_TOTAL_DEF,
	parameter int LEFT_SERVOS = mssl_pkg::LEFT_SERVOS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mssl_pkg::ADDR_W-1:0]   paddr,
	input  logic [mssl_pkg::DATA_W-1:0]   pwdata,
	output logic [mssl_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic [mssl_pkg::NUM_W-1:0]    servo_number,
	input  logic [mssl_pkg::ANGLE_W-1:0]  target_angle,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          write_valid,
	output logic                          controller_side,
	output logic [mssl_pkg::CHAN_W-1:0]   channel,
	output logic [mssl_pkg::COUNT_W-1:0]  pwm_count,
	output logic                          all_settled,
	output logic                          last
);

	localparam int IDX_W = $clog2(SERVO_TOTAL);

	mssl_pkg::cfg_t    cfg;
	mssl_pkg::cmd_t    cmd;
	mssl_pkg::status_t status;
	logic [IDX_W-1:0]  idx;

	// configuration registers
	mssl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// controller
	mssl_ctrl #(
		.SERVO_TOTAL (SERVO_TOTAL),
		.IDX_W       (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.status    (status),
		.cmd       (cmd),
		.idx       (idx)
	);

	// datapath
	mssl_datapath #(
		.SERVO_TOTAL (SERVO_TOTAL),
		.LEFT_SERVOS (LEFT_SERVOS),
		.IDX_W       (IDX_W)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.idx             (idx),
		.status          (status),
		.servo_number    (servo_number),
		.target_angle    (target_angle),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.write_valid     (write_valid),
		.controller_side (controller_side),
		.channel         (channel),
		.pwm_count       (pwm_count),
		.all_settled     (all_settled),
		.last            (last)
	);

endmodule

FILE: verif/tb_multi_servo_slew_limiter.sv
// self-checking testbench for the multi-servo slew limiter: directed table, then random requests
// depends on mssl_pkg and multi_servo_slew_limiter under design/
module tb_multi_servo_slew_limiter;
	timeunit 1ns;
	timeprecision 1ps;

	import mssl_pkg::*;

	localparam int SERVOS        = SERVO_TOTAL_DEF;
	localparam int LEFT_SIDE     = LEFT_SERVOS_DEF;
	localparam int PHASES        = 10;
	localparam int PHASE_ITEMS   = 50;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 400;
	localparam int STUCK_LIMIT   = 3000;
	localparam int ROWS          = 25;

	// one pwm write (or the empty tick result) as seen on the output port
	typedef struct packed {
		logic              write_valid;
		logic              side;
		logic [CHAN_W-1:0] chan;
		logic [COUNT_W-1:0] count;
		logic              settled;
		logic              last;
	} pwm_wr_t;

	// one request; typed rows carry their single result written out by hand
	typedef struct packed {
		logic               op;
		logic [NUM_W-1:0]   num;
		logic [ANGLE_W-1:0] ang;
		logic               typed;
		pwm_wr_t            want;
	} req_row_t;

	localparam pwm_wr_t IDLE_TICK = '{1'b0, 1'b0, 4'd0, 12'd0, 1'b1, 1'b1};
	localparam pwm_wr_t NO_RES    = '0;

	// directed requests under reset settings (step 5, 500 at 0 deg, 100 at 180 deg)
	localparam req_row_t DIRECTED [ROWS] = '{
		'{OP_TICK,       5'd0,  8'd0,   1'b1, IDLE_TICK},  // nothing pending after reset
		'{OP_SET_TARGET, 5'd0,  8'd50,  1'b0, NO_RES},     // servo 0 is ignored
		'{OP_SET_TARGET, 5'd19, 8'd50,  1'b0, NO_RES},     // just past the last servo
		'{OP_SET_TARGET, 5'd31, 8'd255, 1'b0, NO_RES},     // all ones, ignored
		'{OP_TICK,       5'd31, 8'd255, 1'b1, IDLE_TICK},
		'{OP_SET_TARGET, 5'd18, 8'd0,   1'b0, NO_RES},     // target equals preset
		'{OP_TICK,       5'd0,  8'd0,   1'b1, IDLE_TICK},  // cleared without a write
		'{OP_SET_TARGET, 5'd1,  8'd255, 1'b0, NO_RES},     // saturates to 180
		'{OP_SET_TARGET, 5'd9,  8'd178, 1'b0, NO_RES},     // gap within one step
		'{OP_SET_TARGET, 5'd10, 8'd0,   1'b0, NO_RES},
		'{OP_SET_TARGET, 5'd18, 8'd180, 1'b0, NO_RES},
		'{OP_TICK,       5'd0,  8'd0,   1'b0, NO_RES},
		'{OP_SET_TARGET, 5'd1,  8'd0,   1'b0, NO_RES},     // retarget while moving
		'{OP_TICK,       5'd0,  8'd0,   1'b0, NO_RES},
		'{OP_TICK,       5'd0,  8'd0,   1'b0, NO_RES},     // servo 9 was cleared on the previous tick
		'{OP_SET_TARGET, 5'd7,  8'd180, 1'b0, NO_RES},
		'{OP_SET_TARGET, 5'd12, 8'd13,  1'b0, NO_RES},
		'{OP_SET_TARGET, 5'd16, 8'd181, 1'b0, NO_RES},
		'{OP_TICK,       5'd0,  8'd0,   1'b0, NO_RES},
		'{OP_TICK,       5'd0,  8'd0,   1'b0, NO_RES},
		'{OP_SET_TARGET, 5'd5,  8'd0,   1'b0, NO_RES},
		'{OP_TICK,       5'd0,  8'd0,   1'b0, NO_RES},
		'{OP_TICK,       5'd0,  8'd0,   1'b0, NO_RES},
		'{OP_TICK,       5'd0,  8'd0,   1'b0, NO_RES},
		'{OP_TICK,       5'd0,  8'd0,   1'b0, NO_RES}
	};

	// register extremes for the first random phases
	localparam cfg_t EDGE_SETTINGS [4] = '{
		'{8'd0,   12'd0,    12'd4095},
		'{8'd180, 12'd4095, 12'd0},
		'{8'd255, 12'd4095, 12'd4095},
		'{8'd1,   12'd0,    12'd0}
	};

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                in_valid;
	logic                in_stall;
	logic                operation;
	logic [NUM_W-1:0]    servo_number;
	logic [ANGLE_W-1:0]  target_angle;
	logic                out_valid;
	logic                out_stall;
	logic                write_valid;
	logic                controller_side;
	logic [CHAN_W-1:0]   channel;
	logic [COUNT_W-1:0]  pwm_count;
	logic                all_settled;
	logic                last;

	// predictor state
	logic [ANGLE_W-1:0]  ang_now [SERVOS];
	logic [ANGLE_W-1:0]  ang_goal [SERVOS];
	bit                  moving [SERVOS];
	cfg_t                cfg;
	pwm_wr_t             due_writes [$];

	bit                  quiet;
	bit                  hold_req;
	int                  hold_left;
	int                  stuck_cycles;
	int                  mismatches;
	int                  ticks_sent;
	int                  targets_sent;
	int                  writes_seen;

	multi_servo_slew_limiter u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.servo_number    (servo_number),
		.target_angle    (target_angle),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.write_valid     (write_valid),
		.controller_side (controller_side),
		.channel         (channel),
		.pwm_count       (pwm_count),
		.all_settled     (all_settled),
		.last            (last)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// preset angles per group of three on each side, registers at defaults
	function automatic void reset_servos();
		bit right;
		int loc;
		int grp;
		for (int i = 0; i < SERVOS; i++) begin
			right = (i >= LEFT_SIDE);
			loc   = right ? i - LEFT_SIDE : i;
			grp   = loc / GROUP_SIZE;
			case (grp)
				0: begin
					ang_now[i] = PRESET_MID;
				end
				1: begin
					ang_now[i] = right ? PRESET_R1 : PRESET_L1;
				end
				default: begin
					ang_now[i] = right ? PRESET_R2 : PRESET_L2;
				end
			endcase
			ang_goal[i] = ang_now[i];
			moving[i]   = 1'b0;
		end
		cfg = '{STEP_RST, ZERO_RST, FULL_RST};
	endfunction

	// linear angle to off-count map, division truncating toward zero
	function automatic logic [COUNT_W-1:0] angle_to_count(input logic [ANGLE_W-1:0] a);
		int span;
		int val;
		span = int'(cfg.full) - int'(cfg.zero);
		val  = int'(cfg.zero) + (int'(a) * span) / int'(MAX_ANGLE);
		return val[COUNT_W-1:0];
	endfunction

	// one request through the servo state; returns the pwm writes it causes
	function automatic void advance_servos(input req_row_t r, output pwm_wr_t res [$]);
		int      stride;
		int      gap;
		int      nxt;
		bit      settled;
		pwm_wr_t w;
		res = {};
		if (r.op == OP_SET_TARGET) begin
			if (r.num >= 1 && r.num <= SERVOS) begin
				ang_goal[r.num-1] = (r.ang > MAX_ANGLE) ? MAX_ANGLE : r.ang;
				moving[r.num-1]   = 1'b1;
			end
			return;
		end
		stride = (cfg.step == 0) ? 1 : int'(cfg.step);
		for (int i = 0; i < SERVOS; i++) begin
			if (!moving[i])
				continue;
			if (ang_now[i] == ang_goal[i]) begin
				moving[i] = 1'b0;
				continue;
			end
			gap = (ang_goal[i] > ang_now[i]) ? ang_goal[i] - ang_now[i] : ang_now[i] - ang_goal[i];
			if (gap <= stride)
				nxt = ang_goal[i];
			else
				nxt = (ang_goal[i] > ang_now[i]) ? ang_now[i] + stride : ang_now[i] - stride;
			ang_now[i]    = nxt[ANGLE_W-1:0];
			w             = '0;
			w.write_valid = 1'b1;
			w.side        = (i >= LEFT_SIDE);
			w.chan        = CHAN_W'((i >= LEFT_SIDE) ? i - LEFT_SIDE : i);
			w.count       = angle_to_count(ang_now[i]);
			res.push_back(w);
		end
		settled = 1'b1;
		foreach (moving[i])
			if (moving[i])
				settled = 1'b0;
		if (res.size() == 0) begin
			w         = '0;
			w.settled = settled;
			w.last    = 1'b1;
			res.push_back(w);
		end else begin
			foreach (res[k]) begin
				res[k].settled = settled;
				res[k].last    = (k == res.size() - 1);
			end
		end
	endfunction

	// offer one request, predict it once accepted, then maybe idle
	task automatic send_req(input req_row_t r);
		pwm_wr_t res [$];
		in_valid     <= 1'b1;
		operation    <= r.op;
		servo_number <= r.num;
		target_angle <= r.ang;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		advance_servos(r, res);
		if (r.op == OP_TICK) begin
			ticks_sent++;
			if (r.typed)
				res = {r.want};
			foreach (res[k])
				due_writes.push_back(res[k]);
		end else begin
			targets_sent++;
		end
		if (!quiet && $urandom_range(99) < 37) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4))
				@(posedge clk);
		end
	endtask

	// mostly well-formed target/tick mix, some out-of-range noise
	function automatic req_row_t random_row();
		req_row_t r;
		int       roll;
		r    = '0;
		roll = $urandom_range(99);
		if (roll < 35) begin
			r.op  = OP_TICK;
			r.num = NUM_W'($urandom_range(0, 31));
			r.ang = ANGLE_W'($urandom_range(0, 255));
		end else if (roll < 88) begin
			r.op  = OP_SET_TARGET;
			r.num = NUM_W'($urandom_range(1, SERVOS));
			r.ang = ANGLE_W'($urandom_range(0, 180));
		end else if (roll < 94) begin
			r.op  = OP_SET_TARGET;
			r.num = NUM_W'($urandom_range(1, SERVOS));
			r.ang = ANGLE_W'($urandom_range(181, 255));
		end else begin
			r.op  = OP_SET_TARGET;
			r.num = ($urandom_range(1) == 0) ? '0 : NUM_W'($urandom_range(SERVOS + 1, 31));
			r.ang = ANGLE_W'($urandom_range(0, 255));
		end
		return r;
	endfunction

	// apb transfer: setup then access, then the bus is released
	task automatic reg_access(input logic [1:0] idx, input logic wr, input logic [DATA_W-1:0] wdata,
			output logic [DATA_W-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_reg(input logic [1:0] idx, input logic [DATA_W-1:0] want);
		logic [DATA_W-1:0] got;
		reg_access(idx, 1'b0, '0, got);
		if (got !== want) begin
			$error("register %0d readback: expected %0d, got %0d", idx, want, got);
			mismatches++;
		end
	endtask

	// write all three registers while idle and read them back
	task automatic load_settings(input cfg_t s);
		logic [DATA_W-1:0] unused;
		reg_access(REG_STEP, 1'b1, DATA_W'(s.step), unused);
		reg_access(REG_ZERO, 1'b1, DATA_W'(s.zero), unused);
		reg_access(REG_FULL, 1'b1, DATA_W'(s.full), unused);
		cfg = s;
		check_reg(REG_STEP, DATA_W'(s.step));
		check_reg(REG_ZERO, DATA_W'(s.zero));
		check_reg(REG_FULL, DATA_W'(s.full));
	endtask

	// drop valid, wait for every write to arrive, then for the block to go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (due_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// receiver: random stall, or a long counted hold-off on request
	initial begin
		out_stall <= 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 37);
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// result checker and watchdog
	always @(posedge clk) begin
		pwm_wr_t exp_wr;
		if (out_valid && !out_stall) begin
			if (due_writes.size() == 0) begin
				$error("result with nothing expected: write_valid %0d channel %0d count %0d",
					write_valid, channel, pwm_count);
				mismatches++;
			end else begin
				exp_wr = due_writes.pop_front();
				check_field("write_valid", 32'(exp_wr.write_valid), 32'(write_valid));
				check_field("controller_side", 32'(exp_wr.side), 32'(controller_side));
				check_field("channel", 32'(exp_wr.chan), 32'(channel));
				check_field("pwm_count", 32'(exp_wr.count), 32'(pwm_count));
				check_field("all_settled", 32'(exp_wr.settled), 32'(all_settled));
				check_field("last", 32'(exp_wr.last), 32'(last));
				if (exp_wr.write_valid)
					writes_seen++;
			end
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel || !arst_n)
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("timeout: no request or result moved for %0d cycles", STUCK_LIMIT);
			$display("[multi_servo_slew_limiter] ERROR");
			$finish;
		end
	end

	// stimulus
	initial begin
		cfg_t     s;
		req_row_t row;
		int       n_done;
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		operation    <= OP_SET_TARGET;
		servo_number <= '0;
		target_angle <= '0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		quiet        = 1'b0;
		hold_req     = 1'b0;
		stuck_cycles = 0;
		mismatches   = 0;
		ticks_sent   = 0;
		targets_sent = 0;
		writes_seen  = 0;
		reset_servos();
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table under reset settings
		foreach (DIRECTED[k])
			send_req(DIRECTED[k]);
		settle();

		// random phases: register extremes first, then random settings
		for (int p = 0; p < PHASES; p++) begin
			if (p < 4) begin
				s = EDGE_SETTINGS[p];
			end else begin
				s.step = 8'($urandom_range(1, 30));
				s.zero = 12'($urandom_range(0, 4095));
				s.full = 12'($urandom_range(0, 4095));
			end
			load_settings(s);
			quiet = (p == 6);
			if (p == 8)
				hold_req = 1'b1;
			n_done = 0;
			while (n_done < PHASE_ITEMS) begin
				row = random_row();
				send_req(row);
				if (!(row.op == OP_SET_TARGET && (row.num == 0 || row.num > SERVOS)))
					n_done++;
			end
			quiet = 1'b0;
			settle();
		end

		$display("run covered %0d target requests and %0d ticks over %0d register settings,",
			targets_sent, ticks_sent, PHASES + 1);
		$display("with %0d pwm writes checked field by field", writes_seen);
		if (mismatches == 0)
			$display("[multi_servo_slew_limiter] OK");
		else
			$display("[multi_servo_slew_limiter] ERROR");
		$finish;
	end

endmodule
